// ----- hw/rtl/merged_direction_rank_core_defines.svh -----
// assertion macros used by the core rtl file
`ifndef MERGED_DIRECTION_RANK_CORE_DEFINES_SVH
`define MERGED_DIRECTION_RANK_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define MDR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mdr assertion failed");

// next-cycle implication, disabled while reset is held
`define MDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mdr assertion failed");

`endif

// ----- hw/rtl/mdr_pkg.sv -----
package mdr_pkg;

  // block limits
  localparam int MaxPartOrder = 4;
  localparam int MaxBases     = 15;

  // fixed field geometry
  localparam int FieldSlots = 4;
  localparam int MergedMax  = 2 * FieldSlots;
  localparam int CountW     = 3;
  localparam int BaseW      = 4;
  localparam int RankW      = 19;
  localparam int SumW       = RankW + $clog2(MergedMax);
  localparam int BaseVals   = 1 << BaseW;
  localparam longint unsigned RankMax = (64'd1 << RankW) - 64'd1;

  // effective clamp limits
  localparam int PartLim = (MaxPartOrder < FieldSlots) ? MaxPartOrder : FieldSlots;
  localparam int BaseLim = (MaxBases < BaseVals - 1) ? MaxBases : BaseVals - 1;

  localparam int InDataW  = 40;
  localparam int OutDataW = 24;

  // one input item, first field in the lowest bits
  typedef struct packed {
    logic [BaseW-1:0]  second_base_3;
    logic [BaseW-1:0]  second_base_2;
    logic [BaseW-1:0]  second_base_1;
    logic [BaseW-1:0]  second_base_0;
    logic [CountW-1:0] second_count;
    logic [BaseW-1:0]  first_base_3;
    logic [BaseW-1:0]  first_base_2;
    logic [BaseW-1:0]  first_base_1;
    logic [BaseW-1:0]  first_base_0;
    logic [CountW-1:0] first_count;
  } item_t;

  localparam int ItemW = $bits(item_t);

  // merged multiset, unused positions hold base zero
  typedef logic [MergedMax-1:0][BaseW-1:0] merged_t;

  // weight per position and base: C(base + k - 1, k + 1), saturated
  typedef logic [MergedMax-1:0][BaseVals-1:0][RankW-1:0] weight_tab_t;

  function automatic weight_tab_t build_weights();
    weight_tab_t       tab;
    longint unsigned   row [MergedMax+1];
    int                n;
    int                r;
    int                top;
    longint unsigned   val;
    tab = '0;
    for (int k = 0; k < MergedMax; k++) begin
      for (int b = 1; b < BaseVals; b++) begin
        n = b + k - 1;
        r = k + 1;
        for (int j = 0; j <= MergedMax; j++) begin
          row[j] = 64'd0;
        end
        row[0] = 64'd1;
        for (int i = 1; i <= n; i++) begin
          top = (i < r) ? i : r;
          for (int j = top; j >= 1; j--) begin
            row[j] = row[j] + row[j-1];
          end
        end
        val = row[r];
        if (val > RankMax) begin
          val = RankMax;
        end
        tab[k][b] = val[RankW-1:0];
      end
    end
    return tab;
  endfunction

  localparam weight_tab_t WeightTab = build_weights();

endpackage

// ----- hw/rtl/mdr_merge.sv -----
module mdr_merge
  import mdr_pkg::*;
(
  input  item_t   item_i,
  output merged_t merged_o
);

  logic [CountW-1:0]                 na;
  logic [CountW-1:0]                 nb;
  logic [FieldSlots-1:0][BaseW-1:0]  a_raw;
  logic [FieldSlots-1:0][BaseW-1:0]  b_raw;
  logic [FieldSlots-1:0][BaseW-1:0]  a;
  logic [FieldSlots-1:0][BaseW-1:0]  b;

  // clamp counts to the usable list length
  always_comb begin
    na = (item_i.first_count > CountW'(PartLim)) ? CountW'(PartLim) : item_i.first_count;
    nb = (item_i.second_count > CountW'(PartLim)) ? CountW'(PartLim) : item_i.second_count;
  end

  // clamp bases to the base limit
  assign a_raw = {item_i.first_base_3, item_i.first_base_2,
                  item_i.first_base_1, item_i.first_base_0};
  assign b_raw = {item_i.second_base_3, item_i.second_base_2,
                  item_i.second_base_1, item_i.second_base_0};

  always_comb begin
    for (int i = 0; i < FieldSlots; i++) begin
      a[i] = (a_raw[i] > BaseW'(BaseLim)) ? BaseW'(BaseLim) : a_raw[i];
      b[i] = (b_raw[i] > BaseW'(BaseLim)) ? BaseW'(BaseLim) : b_raw[i];
    end
  end

  // two-pointer merge, first list wins ties
  always_comb begin
    logic [CountW-1:0] ia;
    logic [CountW-1:0] ib;
    logic              a_left;
    logic              b_left;
    logic              take_a;
    ia       = '0;
    ib       = '0;
    merged_o = '0;
    for (int k = 0; k < MergedMax; k++) begin
      a_left = (ia < na);
      b_left = (ib < nb);
      take_a = a_left && (!b_left || (a[ia[1:0]] <= b[ib[1:0]]));
      if (take_a) begin
        merged_o[k] = a[ia[1:0]];
        ia          = ia + CountW'(1);
      end else if (b_left) begin
        merged_o[k] = b[ib[1:0]];
        ib          = ib + CountW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/mdr_rank.sv -----
module mdr_rank
  import mdr_pkg::*;
(
  input  merged_t          merged_i,
  output logic [RankW-1:0] rank_o
);

  logic [MergedMax-1:0][RankW-1:0] weight;
  logic [SumW-1:0]                 sum;

  // table lookup per position
  always_comb begin
    for (int k = 0; k < MergedMax; k++) begin
      weight[k] = WeightTab[k][merged_i[k]];
    end
  end

  // add all weights and saturate
  always_comb begin
    sum = '0;
    for (int k = 0; k < MergedMax; k++) begin
      sum = sum + SumW'(weight[k]);
    end
    rank_o = (sum > SumW'(RankMax)) ? RankW'(RankMax) : sum[RankW-1:0];
  end

endmodule

// ----- hw/rtl/merged_direction_rank_core.sv -----
// merged direction rank core
// input stream: one beat carries two sorted base lists with their counts;
// the lists are merged (first list wins ties) and the merged multiset is
// ranked colexicographically, sum over k of C(b_k + k - 1, k + 1), with the
// binomial weights taken from a constant table.
// output stream: one beat per input beat carrying direction_index, in order.
// path: an accepted input beat passes the input register, the merge
// register and the result register in turn before output tvalid rises.
// throughput: one beat per cycle unless the receiver stalls; the merge is
// an eight-step compare chain and the rank is a table lookup plus an
// eight-input adder, each between its own pair of registers.
// stall: when the receiver holds tready low, the pipeline keeps filling
// until every stage is occupied, then s_axis_tready drops; no beat is lost.
// reset: all stage valid bits clear, no output beat is pending.
`include "merged_direction_rank_core_defines.svh"

module merged_direction_rank_core
  import mdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // fields from bit 0: first_count, first_base_0..3, second_count,
  // second_base_0..3, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // fields from bit 0: direction_index, zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i
);

  logic             v0_q, v1_q, v2_q;
  logic             adv0, adv1, adv2;
  item_t            item_q;
  merged_t          merged_d, merged_q;
  logic [RankW-1:0] rank_d, rank_q;

  // stage advance chain
  assign adv2 = !v2_q || m_axis_tready_i;
  assign adv1 = !v1_q || adv2;
  assign adv0 = !v0_q || adv1;
  assign s_axis_tready_o = adv0;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv0) begin
        v0_q <= s_axis_tvalid_i;
      end
      if (adv1) begin
        v1_q <= v0_q;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (adv0 && s_axis_tvalid_i) begin
      item_q <= item_t'(s_axis_tdata_i[ItemW-1:0]);
    end
  end

  // merge stage
  mdr_merge u_merge (
    .item_i   (item_q),
    .merged_o (merged_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv1 && v0_q) begin
      merged_q <= merged_d;
    end
  end

  // rank stage
  mdr_rank u_rank (
    .merged_i (merged_q),
    .rank_o   (rank_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      rank_q <= rank_d;
    end
  end

  // output beat
  assign m_axis_tdata_o  = {{(OutDataW-RankW){1'b0}}, rank_q};
  assign m_axis_tvalid_o = v2_q;

  // checks
  `MDR_ASSERT(empty_out_takes_input, !m_axis_tvalid_o, s_axis_tready_o)
  `MDR_ASSERT_NEXT(merge_moves_to_out, v1_q && !m_axis_tvalid_o, m_axis_tvalid_o)
  `MDR_ASSERT_NEXT(accept_fills_input, s_axis_tvalid_i && s_axis_tready_o, v0_q)

endmodule

// ----- test/direction_rank_checker.sv -----
`timescale 1ns / 1ps

module direction_rank_checker
  import mdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // fields from bit 0: first_count, first_base_0..3, second_count,
  // second_base_0..3, zero fill
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // fields from bit 0: direction_index, zero fill
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // list lengths above this are cut back
  localparam int CountCap = (MaxPartOrder < FieldSlots) ? MaxPartOrder : FieldSlots;
  localparam longint unsigned IndexCap = (64'd1 << RankW) - 64'd1;

  logic [RankW-1:0] expected_index_q [$];
  int               fails;

  // n choose r, zero outside the triangle
  function automatic longint unsigned binom(int n, int r);
    longint unsigned acc;
    if (n < 0 || r < 0 || r > n) begin
      return 64'd0;
    end
    acc = 64'd1;
    for (int i = 0; i < r; i++) begin
      acc = acc * longint'(n - i) / longint'(i + 1);
    end
    return acc;
  endfunction

  // merge both lists (first list wins ties) and rank the merged multiset
  function automatic logic [RankW-1:0] predict_direction_index(item_t it);
    int              fa     [FieldSlots];
    int              sb     [FieldSlots];
    int              merged [2*FieldSlots];
    int              na;
    int              nb;
    int              ia;
    int              ib;
    int              cnt;
    longint unsigned sum;
    fa = '{int'(it.first_base_0), int'(it.first_base_1),
           int'(it.first_base_2), int'(it.first_base_3)};
    sb = '{int'(it.second_base_0), int'(it.second_base_1),
           int'(it.second_base_2), int'(it.second_base_3)};
    na = (int'(it.first_count) > CountCap) ? CountCap : int'(it.first_count);
    nb = (int'(it.second_count) > CountCap) ? CountCap : int'(it.second_count);
    for (int k = 0; k < FieldSlots; k++) begin
      if (fa[k] > MaxBases) begin
        fa[k] = MaxBases;
      end
      if (sb[k] > MaxBases) begin
        sb[k] = MaxBases;
      end
    end
    ia  = 0;
    ib  = 0;
    cnt = 0;
    sum = 64'd0;
    while (ia < na || ib < nb) begin
      if (ia < na && (ib >= nb || fa[ia] <= sb[ib])) begin
        merged[cnt] = fa[ia];
        ia++;
      end else begin
        merged[cnt] = sb[ib];
        ib++;
      end
      cnt++;
    end
    // base zero adds nothing, base one gives a zero weight by itself
    for (int k = 0; k < cnt; k++) begin
      if (merged[k] >= 1) begin
        sum = sum + binom(merged[k] + k - 1, k + 1);
      end
    end
    if (sum > IndexCap) begin
      sum = IndexCap;
    end
    return sum[RankW-1:0];
  endfunction

  // score output beats against the oldest prediction, queue new ones
  always @(posedge clk_i) begin
    logic [RankW-1:0] want;
    logic [RankW-1:0] got;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[RankW-1:0];
        if (expected_index_q.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected output beat: direction_index %0d", got);
          end
          fails++;
        end else begin
          want = expected_index_q.pop_front();
          if (want != got) begin
            if (fails < 10) begin
              $display("mismatch: direction_index expected %0d, actual %0d", want, got);
            end
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_index_q.push_back(predict_direction_index(s_tdata_i[ItemW-1:0]));
      end
      pending_o    <= expected_index_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb
  import mdr_pkg::*;
();

  localparam int IdleLimit = 2000;
  localparam int HoldOff   = 160;

  typedef enum int {RxOpen, RxCoin, RxSparse, RxPattern} rx_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;

  int fail_count;
  int pending;
  int burst_left;
  int idle_cycles;

  merged_direction_rank_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  direction_rank_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic item_t make_item(int fc, int f0, int f1, int f2, int f3,
                                      int sc, int s0, int s1, int s2, int s3);
    item_t it;
    it.first_count   = fc[CountW-1:0];
    it.first_base_0  = f0[BaseW-1:0];
    it.first_base_1  = f1[BaseW-1:0];
    it.first_base_2  = f2[BaseW-1:0];
    it.first_base_3  = f3[BaseW-1:0];
    it.second_count  = sc[CountW-1:0];
    it.second_base_0 = s0[BaseW-1:0];
    it.second_base_1 = s1[BaseW-1:0];
    it.second_base_2 = s2[BaseW-1:0];
    it.second_base_3 = s3[BaseW-1:0];
    return it;
  endfunction

  // nondecreasing bases in 1..hi below cnt, random filler above
  function automatic void sorted_bases(input int cnt, input int hi, output int v[4]);
    int t;
    for (int k = 0; k < 4; k++) begin
      v[k] = $urandom_range(1, hi);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3 - i; j++) begin
        if (v[j] > v[j+1]) begin
          t      = v[j];
          v[j]   = v[j+1];
          v[j+1] = t;
        end
      end
    end
    for (int k = cnt; k < 4; k++) begin
      v[k] = $urandom_range(0, 15);
    end
  endfunction

  // offer one beat, in bursts with random gaps between them
  task automatic send_beat(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tdata_i  <= InDataW'(it);
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
  endtask

  // stimulus and verdict
  initial begin
    int          fa [4];
    int          sb [4];
    int          fc;
    int          sc;
    int          hi;
    logic [63:0] raw;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    burst_left      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest and largest merged directions
    send_beat(make_item(1, 1, 0, 0, 0, 1, 1, 0, 0, 0));
    send_beat(make_item(4, 1, 1, 1, 1, 4, 1, 1, 1, 1));
    send_beat(make_item(4, 15, 15, 15, 15, 4, 15, 15, 15, 15));
    send_beat(make_item(1, 15, 0, 0, 0, 1, 1, 0, 0, 0));
    // empty lists
    send_beat(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_item(0, 7, 9, 3, 12, 3, 2, 5, 9, 1));
    send_beat(make_item(2, 3, 4, 0, 0, 0, 15, 15, 15, 15));
    // counts past the limit
    send_beat(make_item(7, 1, 2, 3, 4, 5, 2, 3, 4, 5));
    send_beat(make_item(6, 15, 15, 15, 15, 4, 1, 1, 1, 1));
    send_beat(make_item(5, 8, 9, 10, 11, 7, 12, 13, 14, 15));
    // zero bases
    send_beat(make_item(4, 0, 0, 0, 0, 4, 0, 3, 7, 15));
    send_beat(make_item(2, 0, 15, 0, 0, 3, 0, 0, 14, 0));
    // unsorted lists
    send_beat(make_item(3, 9, 4, 2, 0, 2, 8, 1, 0, 0));
    send_beat(make_item(4, 15, 1, 15, 1, 4, 2, 14, 3, 13));
    // ties and interleaving
    send_beat(make_item(4, 5, 5, 5, 5, 4, 5, 5, 5, 5));
    send_beat(make_item(2, 6, 10, 0, 0, 3, 2, 6, 11, 0));
    send_beat(make_item(4, 2, 4, 6, 8, 4, 1, 3, 5, 7));
    send_beat(make_item(1, 8, 3, 3, 3, 4, 1, 8, 8, 15));

    // random part: mostly well-formed lists, some raw noise
    repeat (900) begin
      if ($urandom_range(0, 9) < 8) begin
        fc = $urandom_range(1, 4);
        sc = $urandom_range(1, 4);
        hi = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 15;
        sorted_bases(fc, hi, fa);
        sorted_bases(sc, hi, sb);
        send_beat(make_item(fc, fa[0], fa[1], fa[2], fa[3], sc, sb[0], sb[1], sb[2], sb[3]));
      end else begin
        raw = {$urandom(), $urandom()};
        send_beat(raw[ItemW-1:0]);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // drain, then give the pipeline a few more cycles
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: stall pattern per segment, plus one long hold-off
  initial begin
    rx_mode_e   mode;
    int         len;
    logic [7:0] pat;
    m_axis_tready_i = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    for (int seg = 0; ; seg++) begin
      if (seg == 6) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      len  = $urandom_range(4, 48);
      pat  = $urandom();
      repeat (len) begin
        case (mode)
          RxOpen: begin
            m_axis_tready_i <= 1'b1;
          end
          RxCoin: begin
            m_axis_tready_i <= $urandom_range(0, 1);
          end
          RxSparse: begin
            m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            m_axis_tready_i <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/mdr_pkg.sv
hw/rtl/mdr_merge.sv
hw/rtl/mdr_rank.sv
hw/rtl/merged_direction_rank_core.sv
test/direction_rank_checker.sv
test/tb.sv
